### rtl/huffman_code_bit_packer_unit_assert.svh
// Assertion helpers shared by the RTL files of the bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hcbp_pkg.sv
`default_nettype none
package hcbp_pkg;

	localparam int MAX_CODE_LEN = 24;
	localparam int SYMBOL_COUNT = 256;

	localparam int OPC_W   = 2;
	localparam int SYM_W   = 8;
	localparam int CODE_W  = 24;
	localparam int LEN_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int TOTAL_W = 32;
	localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	// Pending bits are kept left aligned in a byte-wide window minus one bit.
	localparam int BUF_W  = BYTE_W - 1;
	localparam int FILL_W = 3;
	// Merge window: pending bits plus the longest code.
	localparam int ACC_W  = 32;
	localparam int CNT_W  = 5;
	localparam int SH_W   = 6;

	localparam int LEN_LIMIT_I = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} opcode_t;

	typedef struct packed {
		logic load_wr;
		logic enc_rd;
		logic flush_ld;
		logic merge;
		logic emit;
		logic wb;
	} hcbp_cmd_t;

	typedef struct packed {
		logic has_byte;
		logic final_byte;
		logic slot_free;
	} hcbp_status_t;

endpackage
`default_nettype wire

### rtl/hcbp_req_if.sv
`default_nettype none
interface hcbp_req_if;
	logic                          valid;
	logic                          ready;
	logic [hcbp_pkg::OPC_W-1:0]    opcode;
	logic [hcbp_pkg::SYM_W-1:0]    symbol;
	logic [hcbp_pkg::CODE_W-1:0]   code_word;
	logic [hcbp_pkg::LEN_W-1:0]    code_length;

	modport source (output valid, output opcode, output symbol, output code_word,
		output code_length, input ready);
	modport sink (input valid, input opcode, input symbol, input code_word,
		input code_length, output ready);
endinterface
`default_nettype wire

### rtl/hcbp_rsp_if.sv
`default_nettype none
interface hcbp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [hcbp_pkg::BYTE_W-1:0]   packed_byte;
	logic                          is_last;
	logic [hcbp_pkg::TOTAL_W-1:0]  total_bits;

	modport source (output valid, output packed_byte, output is_last, output total_bits,
		input ready);
	modport sink (input valid, input packed_byte, input is_last, input total_bits,
		output ready);
endinterface
`default_nettype wire

### rtl/hcbp_table.sv
`default_nettype none
module hcbp_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [hcbp_pkg::IDX_W-1:0]   wr_idx,
	input  wire logic [hcbp_pkg::CODE_W-1:0]  wr_code,
	input  wire logic [hcbp_pkg::LEN_W-1:0]   wr_len,
	input  wire logic                         rd_en,
	input  wire logic [hcbp_pkg::IDX_W-1:0]   rd_idx,
	output logic      [hcbp_pkg::CODE_W-1:0]  rd_code,
	output logic      [hcbp_pkg::LEN_W-1:0]   rd_len
);

	localparam int ENT_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

	logic [ENT_W-1:0]                  mem [hcbp_pkg::SYMBOL_COUNT];
	logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_q;
	logic [ENT_W-1:0]                  rd_data_q;
	logic                              rd_hit_q;

	// A never-written entry reads as zero, so an unloaded symbol emits nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_code, wr_len};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_code = rd_hit_q ? rd_data_q[ENT_W-1:hcbp_pkg::LEN_W] : '0;
	assign rd_len  = rd_hit_q ? rd_data_q[hcbp_pkg::LEN_W-1:0] : '0;

endmodule
`default_nettype wire

### rtl/hcbp_ctrl.sv
`default_nettype none
`include "huffman_code_bit_packer_unit_assert.svh"
module hcbp_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [hcbp_pkg::OPC_W-1:0]  opcode,
	output logic                             in_ready,
	input  wire hcbp_pkg::hcbp_status_t      st,
	output hcbp_pkg::hcbp_cmd_t              cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MERGE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_acc;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						hcbp_pkg::OP_LOAD: begin
							cmd.load_wr = 1'b1;
						end
						hcbp_pkg::OP_ENCODE: begin
							cmd.enc_rd = 1'b1;
							state_d    = S_MERGE;
						end
						hcbp_pkg::OP_FLUSH: begin
							cmd.flush_ld = 1'b1;
							state_d      = S_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			S_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (st.has_byte) begin
					if (st.slot_free) begin
						cmd.emit = 1'b1;
						// Write the leftover bits back along with the last byte.
						if (st.final_byte) begin
							cmd.wb  = 1'b1;
							state_d = S_IDLE;
						end
					end
				end else begin
					cmd.wb  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`HCBP_ASSERT_NEXT(a_enc_to_merge, clk, arst_n,
		in_acc && (opcode == hcbp_pkg::OP_ENCODE), state_q == S_MERGE,
		"accepted encode item did not start a table merge")
	`HCBP_ASSERT_NEXT(a_empty_to_idle, clk, arst_n,
		(state_q == S_EMIT) && !st.has_byte, state_q == S_IDLE,
		"emit state lingered with no complete byte")

endmodule
`default_nettype wire

### rtl/hcbp_dp.sv
`default_nettype none
`include "huffman_code_bit_packer_unit_assert.svh"
module hcbp_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hcbp_pkg::hcbp_cmd_t           cmd,
	output hcbp_pkg::hcbp_status_t             st,
	input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
	input  wire logic [hcbp_pkg::CODE_W-1:0]   code_word,
	input  wire logic [hcbp_pkg::LEN_W-1:0]    code_length,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [hcbp_pkg::BYTE_W-1:0]   packed_byte,
	output logic                               is_last,
	output logic      [hcbp_pkg::TOTAL_W-1:0]  total_bits
);

	localparam int ACC_W  = hcbp_pkg::ACC_W;
	localparam int BYTE_W = hcbp_pkg::BYTE_W;
	localparam int BUF_W  = hcbp_pkg::BUF_W;
	localparam int CNT_W  = hcbp_pkg::CNT_W;
	localparam int SH_W   = hcbp_pkg::SH_W;
	localparam logic [CNT_W-1:0] CNT_BYTE = CNT_W'(BYTE_W);

	logic [BUF_W-1:0]                    buf_q;
	logic [hcbp_pkg::FILL_W-1:0]         fill_q;
	logic [hcbp_pkg::TOTAL_W-1:0]        total_q;
	logic [ACC_W-1:0]                    acc_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                last_q;
	logic                                out_valid_q;
	logic [BYTE_W-1:0]                   out_byte_q;
	logic                                out_last_q;
	logic [hcbp_pkg::TOTAL_W-1:0]        out_total_q;

	logic                                sym_ok;
	logic [hcbp_pkg::IDX_W-1:0]          sym_idx;
	logic [hcbp_pkg::LEN_W-1:0]          len_clamped;
	logic [hcbp_pkg::CODE_W-1:0]         rd_code;
	logic [hcbp_pkg::LEN_W-1:0]          rd_len;
	logic [hcbp_pkg::CODE_W-1:0]         code_m;
	logic [CNT_W-1:0]                    merge_cnt;
	logic [SH_W-1:0]                     merge_sh;
	logic [ACC_W-1:0]                    merge_acc;
	logic [hcbp_pkg::TOTAL_W:0]          total_sum;
	logic [hcbp_pkg::TOTAL_W-1:0]        total_sat;
	logic [ACC_W-1:0]                    acc_nx;
	logic [CNT_W-1:0]                    cnt_nx;

	assign sym_ok      = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT);
	assign sym_idx     = symbol[hcbp_pkg::IDX_W-1:0];
	assign len_clamped = (code_length > hcbp_pkg::LEN_LIMIT) ? hcbp_pkg::LEN_LIMIT : code_length;

	// Out-of-range symbols are masked after the table read and so look unloaded.
	hcbp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd.load_wr && sym_ok),
		.wr_idx  (sym_idx),
		.wr_code (code_word),
		.wr_len  (len_clamped),
		.rd_en   (cmd.enc_rd),
		.rd_idx  (sym_idx),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	logic rd_ok_q;

	// Place the code right below the pending bits in a left-aligned window.
	assign code_m    = rd_ok_q ? (rd_code & ~({hcbp_pkg::CODE_W{1'b1}} << rd_len)) : '0;
	assign merge_cnt = CNT_W'({2'b00, fill_q}) + (rd_ok_q ? CNT_W'(rd_len) : '0);
	assign merge_sh  = SH_W'(ACC_W) - {1'b0, merge_cnt};
	assign merge_acc = {buf_q, {(ACC_W - BUF_W){1'b0}}}
		| (ACC_W'(code_m) << merge_sh);

	assign total_sum = {1'b0, total_q}
		+ (hcbp_pkg::TOTAL_W + 1)'(rd_ok_q ? rd_len : '0);
	assign total_sat = total_sum[hcbp_pkg::TOTAL_W] ? '1 : total_sum[hcbp_pkg::TOTAL_W-1:0];

	assign acc_nx = cmd.emit ? (acc_q << BYTE_W) : acc_q;
	assign cnt_nx = cmd.emit ? (cnt_q - CNT_BYTE) : cnt_q;

	assign st.has_byte   = (cnt_q >= CNT_BYTE);
	assign st.final_byte = (cnt_q < (CNT_BYTE + CNT_BYTE));
	assign st.slot_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.enc_rd) begin
				rd_ok_q <= sym_ok;
			end
			if (cmd.merge) begin
				cnt_q   <= merge_cnt;
				total_q <= total_sat;
			end else if (cmd.flush_ld) begin
				cnt_q <= (fill_q != '0) ? CNT_BYTE : '0;
			end else begin
				cnt_q <= cnt_nx;
			end
			if (cmd.wb) begin
				buf_q  <= acc_nx[ACC_W-1 -: BUF_W];
				fill_q <= cnt_nx[hcbp_pkg::FILL_W-1:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			acc_q  <= merge_acc;
			last_q <= 1'b0;
		end else if (cmd.flush_ld) begin
			// Pending bits are already left aligned; the pad is the zeros below.
			acc_q  <= {buf_q, {(ACC_W - BUF_W){1'b0}}};
			last_q <= 1'b1;
		end else begin
			acc_q <= acc_nx;
		end
		if (cmd.emit) begin
			out_byte_q  <= acc_q[ACC_W-1 -: BYTE_W];
			out_last_q  <= last_q;
			out_total_q <= total_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = out_byte_q;
	assign is_last     = out_last_q;
	assign total_bits  = out_total_q;

	`HCBP_ASSERT_IMPL(a_empty_buf_zero, clk, arst_n,
		fill_q == '0, buf_q == '0,
		"bit buffer holds stray bits while empty")
	`HCBP_ASSERT_NEXT(a_total_monotonic, clk, arst_n,
		1'b1, total_q >= $past(total_q),
		"running bit total went backwards")
	`HCBP_ASSERT_IMPL(a_flush_one_byte, clk, arst_n,
		last_q && st.has_byte, cnt_q == CNT_BYTE,
		"flush produced more than one byte")

endmodule
`default_nettype wire

### rtl/huffman_code_bit_packer_unit.sv
`default_nettype none
// Channel   Dir  Fields                                          Taken when
// request   in   opcode, symbol, code_word, code_length          valid && ready
// response  out  packed_byte, is_last, total_bits                valid && ready
//
// A load item is taken in the idle state; a flush loads the pending bits, padded with
// zeros, and emits them if any; an encode does the registered table read, a merge state,
// then emits its n output bytes (n <= 3) one byte per cycle while the result register is free.
// Reset clears the table valid bits at once, so every symbol reads as unloaded.
// A full result register that is not taken stalls byte emission; the next item is
// accepted while the final byte of the previous one still waits.
module huffman_code_bit_packer_unit (
	input wire logic     clk,
	input wire logic     arst_n,
	hcbp_req_if.sink     request,
	hcbp_rsp_if.source   response
);

	hcbp_pkg::hcbp_cmd_t    cmd;
	hcbp_pkg::hcbp_status_t st;
	logic                   in_ready;

	assign request.ready = in_ready;

	hcbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.opcode   (request.opcode),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	hcbp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.symbol      (request.symbol),
		.code_word   (request.code_word),
		.code_length (request.code_length),
		.out_valid   (response.valid),
		.out_ready   (response.ready),
		.packed_byte (response.packed_byte),
		.is_last     (response.is_last),
		.total_bits  (response.total_bits)
	);

endmodule
`default_nettype wire

### test/hcbp_byte_checker.sv
`timescale 1ns / 1ps
module hcbp_byte_checker
	import hcbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hcbp_req_if  request,
	hcbp_rsp_if  response,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} code_entry_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  packed_byte;
		logic               is_last;
		logic [TOTAL_W-1:0] total_bits;
	} packed_result_t;

	code_entry_t        code_table [SYMBOL_COUNT];
	logic [BYTE_W-1:0]  pend_bits;
	int unsigned        pend_count;
	logic [TOTAL_W-1:0] bit_total;
	packed_result_t     expected_bytes [$];

	task automatic emit_byte(input logic [BYTE_W-1:0] value, input logic last);
		expected_bytes.push_back('{packed_byte: value, is_last: last, total_bits: bit_total});
	endtask

	task automatic pack_request(input logic [OPC_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
		code_entry_t      entry;
		logic [TOTAL_W:0] sum;
		case (op)
			OP_LOAD: begin
				entry.code = word;
				entry.len  = (len > LEN_LIMIT) ? LEN_LIMIT : len;
				if (sym < SYMBOL_COUNT)
					code_table[sym] = entry;
			end
			OP_ENCODE: begin
				entry = (sym < SYMBOL_COUNT) ? code_table[sym] : '0;
				sum = {1'b0, bit_total} + entry.len;
				bit_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
				// Code bits go out most significant first; every eighth bit closes a byte.
				for (int i = int'(entry.len); i > 0; i--) begin
					pend_bits = {pend_bits[BYTE_W-2:0], entry.code[i-1]};
					pend_count++;
					if (pend_count == BYTE_W) begin
						emit_byte(pend_bits, 1'b0);
						pend_bits  = '0;
						pend_count = 0;
					end
				end
			end
			OP_FLUSH: begin
				if (pend_count != 0)
					emit_byte(pend_bits << (BYTE_W - pend_count), 1'b1);
				pend_bits  = '0;
				pend_count = 0;
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [TOTAL_W-1:0] want,
			input logic [TOTAL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_result_t want;
		if (!arst_n) begin
			foreach (code_table[k])
				code_table[k] = '0;
			pend_bits  = '0;
			pend_count = 0;
			bit_total  = '0;
			expected_bytes.delete();
			mismatches = 0;
		end else begin
			if (response.valid && response.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("packed_byte: expected none, got 0x%0h", response.packed_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					compare_field("packed_byte", want.packed_byte, response.packed_byte);
					compare_field("is_last", want.is_last, response.is_last);
					compare_field("total_bits", want.total_bits, response.total_bits);
				end
			end
			if (request.valid && request.ready)
				pack_request(request.opcode, request.symbol, request.code_word,
					request.code_length);
		end
		outstanding = expected_bytes.size();
	end

endmodule

### test/huffman_code_bit_packer_unit_tb.sv
`timescale 1ns / 1ps
module huffman_code_bit_packer_unit_tb;
	import hcbp_pkg::*;

	localparam logic [OPC_W-1:0] OP_RESERVED = 2'd3;
	localparam int          CLK_PERIOD    = 8;
	localparam int          RESET_CYCLES  = 12;
	localparam int          RANDOM_ITEMS  = 95;
	localparam int          MAX_WAIT      = 19;
	localparam int          SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	logic             clk;
	logic             arst_n;
	int               mismatches;
	int               outstanding;
	int unsigned      cycle_count;
	bit               no_idle;
	logic [SYM_W-1:0] loaded_syms [$];

	hcbp_req_if req_ch ();
	hcbp_rsp_if rsp_ch ();

	huffman_code_bit_packer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	hcbp_byte_checker u_byte_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (req_ch),
		.response    (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL huffman_code_bit_packer_unit");
		$finish;
	end

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic send_item(input logic [OPC_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.symbol      <= sym;
		req_ch.code_word   <= word;
		req_ch.code_length <= len;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] word,
			input logic [LEN_W-1:0] len);
		send_item(OP_LOAD, sym, word, len);
		loaded_syms.push_back(sym);
	endtask

	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [LEN_W-1:0] random_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return '0;
		if (pick < 16)
			return LEN_W'($urandom_range(25, 31));
		return LEN_W'($urandom_range(1, MAX_CODE_LEN));
	endfunction

	// Most items encode symbols that hold a code; the rest are loads, flushes and noise.
	task automatic random_item();
		int               pick;
		logic [SYM_W-1:0] sym;
		logic [CODE_W-1:0] word;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		sym  = SYM_W'($urandom);
		word = CODE_W'($urandom);
		len  = LEN_W'($urandom);
		if (pick < 18) begin
			load_entry(sym, word, random_length());
		end else if (pick < 82) begin
			if (loaded_syms.size() > 0 && $urandom_range(0, 4) != 0)
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
			send_item(OP_ENCODE, sym, word, len);
		end else if (pick < 96) begin
			send_item(OP_FLUSH, sym, word, len);
		end else begin
			send_item(OP_RESERVED, sym, word, len);
		end
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.opcode      = '0;
		req_ch.symbol      = '0;
		req_ch.code_word   = '0;
		req_ch.code_length = '0;
		rsp_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		no_idle            = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Nothing is loaded yet, so neither of these produces a byte.
		send_item(OP_ENCODE, 8'd5, '1, '1);
		send_item(OP_FLUSH, 8'd0, '0, '0);
		load_entry(8'd0, 24'hFFFFFF, 5'd24);
		// Only the low three bits of this code word count.
		load_entry(8'd255, 24'hABCDE5, 5'd3);
		// Lengths beyond the code word width are clamped.
		load_entry(8'd1, 24'h5A5A5A, 5'd31);
		load_entry(8'd2, 24'h000001, 5'd25);
		load_entry(8'd3, 24'hFFFFFF, 5'd0);
		// The reserved opcode must not overwrite entry zero.
		send_item(OP_RESERVED, 8'd0, 24'h000000, 5'd1);
		send_item(OP_ENCODE, 8'd0, '0, '0);
		send_item(OP_ENCODE, 8'd255, '0, '0);
		send_item(OP_ENCODE, 8'd3, '0, '0);
		send_item(OP_FLUSH, 8'd0, '0, '0);
		send_item(OP_ENCODE, 8'd1, '0, '0);
		send_item(OP_ENCODE, 8'd2, '0, '0);
		send_item(OP_ENCODE, 8'd255, '0, '0);
		send_item(OP_ENCODE, 8'd255, '0, '0);
		send_item(OP_ENCODE, 8'd255, '0, '0);
		send_item(OP_ENCODE, 8'd0, '0, '0);
		send_item(OP_FLUSH, 8'd0, '0, '0);
		send_item(OP_FLUSH, 8'd0, '0, '0);
		load_entry(8'd4, 24'h00007F, 5'd7);
		send_item(OP_ENCODE, 8'd4, '0, '0);
		send_item(OP_FLUSH, 8'd0, '0, '0);
		pause_until_drained();

		for (int n = 0; n < 12; n++)
			load_entry(SYM_W'($urandom), CODE_W'($urandom), random_length());
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_ITEMS / 2)
				pause_until_drained();
			random_item();
		end

		no_idle = 1'b0;
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS huffman_code_bit_packer_unit");
		end else begin
			$display("FAIL huffman_code_bit_packer_unit");
		end
		$finish;
	end

endmodule
